@@ hdl/smi_pkg.sv @@
// Shared widths and codes for the small matrix inverse unit.
// No dependencies; imported by every module of the block.
`default_nettype none
package smi_pkg;
	localparam int ELEM_W            = 16;
	localparam int ELEMENT_WIDTH_DEF = 16;
	localparam int N_ELEM            = 9;
	localparam int PROD_W            = 2 * ELEM_W;
	localparam int COF_W             = PROD_W + 1;
	localparam int DET_W             = 49;
	localparam int DMAG_W            = DET_W - 1;
	localparam int CMAG_W            = PROD_W;
	localparam int INV_W             = 32;
	localparam int DIV_STEPS         = INV_W;
	localparam int CFG_W             = 2;
	localparam int DET2_SHIFT        = 8;

	localparam logic [CFG_W-1:0] SIZE_2X2   = 2'd2;
	localparam logic [CFG_W-1:0] SIZE_RESET = 2'd3;

	localparam logic signed [INV_W-1:0] INV_MAX = {1'b0, {(INV_W-1){1'b1}}};
	localparam logic signed [INV_W-1:0] INV_MIN = {1'b1, {(INV_W-1){1'b0}}};
endpackage
`default_nettype wire

@@ hdl/smi_div_lane.sv @@
// One divider lane: pipelined restoring divide of (cofactor << 32) by |det|,
// one quotient bit per stage, saturated to signed Q16.16 (2x2) or Q8.24 (3x3). Uses smi_pkg.
`default_nettype none
module smi_div_lane (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic [smi_pkg::CMAG_W-1:0]        cmag,
	input  wire logic [smi_pkg::DMAG_W-1:0]        dmag,
	input  wire logic                              neg,
	output logic signed [smi_pkg::INV_W-1:0]       quot
);
	import smi_pkg::*;

	logic [DMAG_W-1:0] rem_s [0:DIV_STEPS];
	logic [DMAG_W-1:0] den_s [0:DIV_STEPS];
	logic [INV_W-1:0]  quo_s [0:DIV_STEPS];
	logic              neg_s [0:DIV_STEPS];
	logic              sat_s [0:DIV_STEPS];
	logic [INV_W-1:0]  q_fin;

	// quotient reaches 2^32 exactly when |num| >= |den|
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= DMAG_W'(cmag);
			den_s[0] <= dmag;
			quo_s[0] <= '0;
			neg_s[0] <= neg;
			sat_s[0] <= (DMAG_W'(cmag) >= dmag);
		end
	end

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
		logic [DMAG_W+1:0] diff;
		assign diff = {1'b0, rem_s[k-1], 1'b0} - {2'b00, den_s[k-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= diff[DMAG_W+1] ? {rem_s[k-1][DMAG_W-2:0], 1'b0} : diff[DMAG_W-1:0];
				quo_s[k] <= {quo_s[k-1][INV_W-2:0], ~diff[DMAG_W+1]};
				den_s[k] <= den_s[k-1];
				neg_s[k] <= neg_s[k-1];
				sat_s[k] <= sat_s[k-1];
			end
		end
	end

	assign q_fin = quo_s[DIV_STEPS];

	always_comb begin
		if (sat_s[DIV_STEPS]) begin
			quot = neg_s[DIV_STEPS] ? INV_MIN : INV_MAX;
		end else if (!neg_s[DIV_STEPS]) begin
			quot = q_fin[INV_W-1] ? INV_MAX : $signed(q_fin);
		end else if (q_fin[INV_W-1] && (|q_fin[INV_W-2:0])) begin
			quot = INV_MIN;
		end else begin
			quot = $signed(~q_fin + INV_W'(1));
		end
	end
endmodule
`default_nettype wire

@@ hdl/small_matrix_inverse_unit.sv @@
// Small matrix inverse unit top level: cofactors, determinant, nine divider lanes.
// Depends on smi_pkg and smi_div_lane.
//
// Accepts one 2x2 or 3x3 Q8.8 matrix per clock while in_ready is high and returns
// its Q24.24 determinant and saturated inverse (Q16.16 in 2x2 mode, Q8.24 in 3x3
// mode) through six front-end stages, 33 stages in each divider lane and one output
// register. The divider lanes retire one quotient bit per stage. The whole
// pipeline stalls only while a finished word waits at the output and out_ready
// is low. A zero determinant gives singular = 1 and an all-zero inverse.
// matrix_size = 2 selects 2x2 mode; other codes mean 3x3.
`default_nettype none
module small_matrix_inverse_unit #(
	parameter int ELEMENT_WIDTH = smi_pkg::ELEMENT_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [smi_pkg::CFG_W-1:0]         cfg_wdata,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic signed [smi_pkg::ELEM_W-1:0] m00,
	input  wire logic signed [smi_pkg::ELEM_W-1:0] m01,
	input  wire logic signed [smi_pkg::ELEM_W-1:0] m02,
	input  wire logic signed [smi_pkg::ELEM_W-1:0] m10,
	input  wire logic signed [smi_pkg::ELEM_W-1:0] m11,
	input  wire logic signed [smi_pkg::ELEM_W-1:0] m12,
	input  wire logic signed [smi_pkg::ELEM_W-1:0] m20,
	input  wire logic signed [smi_pkg::ELEM_W-1:0] m21,
	input  wire logic signed [smi_pkg::ELEM_W-1:0] m22,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [smi_pkg::INV_W-1:0]       inv00,
	output logic signed [smi_pkg::INV_W-1:0]       inv01,
	output logic signed [smi_pkg::INV_W-1:0]       inv02,
	output logic signed [smi_pkg::INV_W-1:0]       inv10,
	output logic signed [smi_pkg::INV_W-1:0]       inv11,
	output logic signed [smi_pkg::INV_W-1:0]       inv12,
	output logic signed [smi_pkg::INV_W-1:0]       inv20,
	output logic signed [smi_pkg::INV_W-1:0]       inv21,
	output logic signed [smi_pkg::INV_W-1:0]       inv22,
	output logic signed [smi_pkg::DET_W-1:0]       det_value,
	output logic                                   singular
);
	import smi_pkg::*;

	localparam int EW_EFF   = (ELEMENT_WIDTH < ELEM_W) ? ELEMENT_WIDTH : ELEM_W;
	localparam int EXT_SH   = ELEM_W - EW_EFF;
	localparam int FRONT    = 6;
	localparam int LANE_LAT = DIV_STEPS + 1;
	localparam int PIPE_LEN = FRONT + LANE_LAT;

	// cofactor i = a[PA_L]*a[PA_R] - a[PB_L]*a[PB_R]
	localparam int PA_L [N_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
	localparam int PA_R [N_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
	localparam int PB_L [N_ELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
	localparam int PB_R [N_ELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

	logic [CFG_W-1:0] matrix_size_q;
	logic             en;
	logic             vld_q [0:PIPE_LEN-1];
	logic             out_valid_q;

	logic signed [ELEM_W-1:0] in_elem [N_ELEM];
	logic signed [ELEM_W-1:0] ext_elem [N_ELEM];

	logic signed [ELEM_W-1:0] elem_s1 [N_ELEM];
	logic                     mode2_s1;
	logic signed [ELEM_W-1:0] elem_s2 [N_ELEM];
	logic signed [PROD_W-1:0] pa_s2 [N_ELEM];
	logic signed [PROD_W-1:0] pb_s2 [N_ELEM];
	logic                     mode2_s2;
	logic signed [COF_W-1:0]  cof_n [N_ELEM];
	logic signed [COF_W-1:0]  cof_s3 [N_ELEM];
	logic signed [COF_W-1:0]  det2_s3;
	logic signed [ELEM_W-1:0] row0_s3 [3];
	logic                     mode2_s3;
	logic signed [DET_W-1:0]  term_s4 [3];
	logic signed [COF_W-1:0]  cof_s4 [N_ELEM];
	logic signed [COF_W-1:0]  det2_s4;
	logic                     mode2_s4;
	logic signed [DET_W-1:0]  det_s5;
	logic signed [COF_W-1:0]  cof_s5 [N_ELEM];
	logic signed [DET_W-1:0]  det_s6;
	logic [DMAG_W-1:0]        dmag_s6;
	logic                     dneg_s6;
	logic                     sing_s6;
	logic [CMAG_W-1:0]        cmag_s6 [N_ELEM];
	logic                     cneg_s6 [N_ELEM];

	logic signed [DET_W-1:0]  det_d [0:LANE_LAT-1];
	logic                     sing_d [0:LANE_LAT-1];
	logic signed [INV_W-1:0]  quot [N_ELEM];

	logic signed [INV_W-1:0]  inv_q [N_ELEM];
	logic signed [DET_W-1:0]  det_q;
	logic                     sing_q;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_size_q <= SIZE_RESET;
		end else if (cfg_we) begin
			matrix_size_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PIPE_LEN; k++) vld_q[k] <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_valid;
			for (int k = 1; k < PIPE_LEN; k++) vld_q[k] <= vld_q[k-1];
			out_valid_q <= vld_q[PIPE_LEN-1];
		end
	end

	assign in_elem[0] = m00;
	assign in_elem[1] = m01;
	assign in_elem[2] = m02;
	assign in_elem[3] = m10;
	assign in_elem[4] = m11;
	assign in_elem[5] = m12;
	assign in_elem[6] = m20;
	assign in_elem[7] = m21;
	assign in_elem[8] = m22;

	always_comb begin
		for (int i = 0; i < N_ELEM; i++) begin
			ext_elem[i] = (in_elem[i] <<< EXT_SH) >>> EXT_SH;
		end
	end

	// 2x2 mode: adjugate is the swapped diagonal and negated off-diagonal
	always_comb begin
		for (int i = 0; i < N_ELEM; i++) begin
			cof_n[i] = mode2_s2 ? '0 : COF_W'(pa_s2[i]) - COF_W'(pb_s2[i]);
		end
		if (mode2_s2) begin
			cof_n[0] = COF_W'(elem_s2[4]);
			cof_n[1] = -COF_W'(elem_s2[1]);
			cof_n[3] = -COF_W'(elem_s2[3]);
			cof_n[4] = COF_W'(elem_s2[0]);
		end
	end

	// front end: elements, products, cofactors, row-0 terms, determinant, magnitudes
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N_ELEM; i++) elem_s1[i] <= ext_elem[i];
			mode2_s1 <= (matrix_size_q == SIZE_2X2);

			for (int i = 0; i < N_ELEM; i++) begin
				elem_s2[i] <= elem_s1[i];
				pa_s2[i]   <= PROD_W'(elem_s1[PA_L[i]]) * PROD_W'(elem_s1[PA_R[i]]);
				pb_s2[i]   <= PROD_W'(elem_s1[PB_L[i]]) * PROD_W'(elem_s1[PB_R[i]]);
			end
			mode2_s2 <= mode2_s1;

			for (int i = 0; i < N_ELEM; i++) cof_s3[i] <= cof_n[i];
			det2_s3 <= COF_W'(pa_s2[8]) - COF_W'(pb_s2[8]);
			for (int i = 0; i < 3; i++) row0_s3[i] <= elem_s2[i];
			mode2_s3 <= mode2_s2;

			term_s4[0] <= DET_W'(row0_s3[0]) * DET_W'(cof_s3[0]);
			term_s4[1] <= DET_W'(row0_s3[1]) * DET_W'(cof_s3[3]);
			term_s4[2] <= DET_W'(row0_s3[2]) * DET_W'(cof_s3[6]);
			for (int i = 0; i < N_ELEM; i++) cof_s4[i] <= cof_s3[i];
			det2_s4  <= det2_s3;
			mode2_s4 <= mode2_s3;

			det_s5 <= mode2_s4 ? DET_W'(det2_s4) <<< DET2_SHIFT :
				term_s4[0] + term_s4[1] + term_s4[2];
			for (int i = 0; i < N_ELEM; i++) cof_s5[i] <= cof_s4[i];

			det_s6  <= det_s5;
			dmag_s6 <= det_s5[DET_W-1] ? DMAG_W'(-det_s5) : DMAG_W'(det_s5);
			dneg_s6 <= det_s5[DET_W-1];
			sing_s6 <= (det_s5 == '0);
			for (int i = 0; i < N_ELEM; i++) begin
				cmag_s6[i] <= cof_s5[i][COF_W-1] ? CMAG_W'(-cof_s5[i]) : CMAG_W'(cof_s5[i]);
				cneg_s6[i] <= cof_s5[i][COF_W-1];
			end
		end
	end

	for (genvar i = 0; i < N_ELEM; i++) begin : g_lane
		smi_div_lane u_lane (
			.clk  (clk),
			.en   (en),
			.cmag (cmag_s6[i]),
			.dmag (dmag_s6),
			.neg  (cneg_s6[i] ^ dneg_s6),
			.quot (quot[i])
		);
	end

	// merge: align determinant with the lanes, zero the inverse when singular
	always_ff @(posedge clk) begin
		if (en) begin
			det_d[0]  <= det_s6;
			sing_d[0] <= sing_s6;
			for (int k = 1; k < LANE_LAT; k++) begin
				det_d[k]  <= det_d[k-1];
				sing_d[k] <= sing_d[k-1];
			end
			for (int i = 0; i < N_ELEM; i++) begin
				inv_q[i] <= sing_d[LANE_LAT-1] ? '0 : quot[i];
			end
			det_q  <= det_d[LANE_LAT-1];
			sing_q <= sing_d[LANE_LAT-1];
		end
	end

	assign out_valid = out_valid_q;
	assign inv00     = inv_q[0];
	assign inv01     = inv_q[1];
	assign inv02     = inv_q[2];
	assign inv10     = inv_q[3];
	assign inv11     = inv_q[4];
	assign inv12     = inv_q[5];
	assign inv20     = inv_q[6];
	assign inv21     = inv_q[7];
	assign inv22     = inv_q[8];
	assign det_value = det_q;
	assign singular  = sing_q;
endmodule
`default_nettype wire

@@ hdl/smi_checker.sv @@
// Port-level checks for small_matrix_inverse_unit, attached by bind.
// Depends on smi_pkg and the top level's port list.
`default_nettype none
module smi_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_ready,
	input wire logic                              out_valid,
	input wire logic                              out_ready,
	input wire logic signed [smi_pkg::INV_W-1:0]  inv00,
	input wire logic signed [smi_pkg::INV_W-1:0]  inv22,
	input wire logic signed [smi_pkg::DET_W-1:0]  det_value,
	input wire logic                              singular
);
	import smi_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(det_value))
		else $error("output word changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input not ready with empty output");

	a_sing_det: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (singular == (det_value == '0)))
		else $error("singular flag disagrees with determinant");

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> inv00 == '0 && inv22 == '0)
		else $error("singular word has nonzero inverse");
endmodule

bind small_matrix_inverse_unit smi_checker u_smi_checker (.*);
`default_nettype wire

@@ tb/tb_top.sv @@
// Testbench for small_matrix_inverse_unit: random and directed 2x2/3x3 matrices.
// Self-contained; checks determinant, singular flag and Q16.16 (2x2) or Q8.24 (3x3) inverse per word.
// Depends on smi_pkg and the RTL of the unit.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import smi_pkg::*;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef struct {
		logic signed [INV_W-1:0] inv [9];
		logic signed [DET_W-1:0] det;
		logic                    sing;
	} inverse_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = SIZE_RESET;
	logic in_valid = 1'b0;
	logic in_ready;
	elem_t m [9];
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [INV_W-1:0] inv [9];
	logic signed [DET_W-1:0] det_value;
	logic singular;

	logic [CFG_W-1:0] size_reg = SIZE_RESET;
	inverse_t expected_q [$];
	int mismatches = 0;
	int idle_cycles = 0;
	int gap_left = 0;
	int burst_left = 0;

	initial for (int i = 0; i < 9; i++) m[i] = '0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	small_matrix_inverse_unit DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.m00(m[0]), .m01(m[1]), .m02(m[2]), .m10(m[3]), .m11(m[4]), .m12(m[5]),
		.m20(m[6]), .m21(m[7]), .m22(m[8]),
		.out_valid(out_valid), .out_ready(out_ready),
		.inv00(inv[0]), .inv01(inv[1]), .inv02(inv[2]), .inv10(inv[3]), .inv11(inv[4]),
		.inv12(inv[5]), .inv20(inv[6]), .inv21(inv[7]), .inv22(inv[8]),
		.det_value(det_value), .singular(singular)
	);

	function automatic logic signed [INV_W-1:0] q16_quotient(longint num, longint den);
		longint q;
		q = (num * 64'sd16777216) / den;
		if (q > longint'(INV_MAX)) return INV_MAX;
		if (q < longint'(INV_MIN)) return INV_MIN;
		return q[INV_W-1:0];
	endfunction

	function automatic inverse_t invert_matrix(elem_t a_in [9], logic [CFG_W-1:0] sz);
		inverse_t r;
		longint a [9];
		longint c [9];
		longint d;
		for (int i = 0; i < 9; i++) begin
			a[i] = a_in[i];
			r.inv[i] = '0;
		end
		if (sz == SIZE_2X2) begin
			d = a[0] * a[4] - a[1] * a[3];
			r.det = DET_W'(d * 256);
			r.sing = (d == 0);
			if (d != 0) begin
				r.inv[0] = q16_quotient(a[4], d);
				r.inv[1] = q16_quotient(-a[1], d);
				r.inv[3] = q16_quotient(-a[3], d);
				r.inv[4] = q16_quotient(a[0], d);
			end
		end else begin
			c[0] = a[4] * a[8] - a[5] * a[7];
			c[1] = a[2] * a[7] - a[1] * a[8];
			c[2] = a[1] * a[5] - a[2] * a[4];
			c[3] = a[5] * a[6] - a[3] * a[8];
			c[4] = a[0] * a[8] - a[2] * a[6];
			c[5] = a[2] * a[3] - a[0] * a[5];
			c[6] = a[3] * a[7] - a[4] * a[6];
			c[7] = a[1] * a[6] - a[0] * a[7];
			c[8] = a[0] * a[4] - a[1] * a[3];
			d = a[0] * c[0] + a[1] * c[3] + a[2] * c[6];
			r.det = DET_W'(d);
			r.sing = (d == 0);
			if (d != 0)
				for (int i = 0; i < 9; i++) r.inv[i] = q16_quotient(c[i] * 256, d);
		end
		return r;
	endfunction

	// receiver stall pattern
	always @(posedge clk) begin
		if (($urandom_range(0, 255) < 32) || out_ready == 1'b1)
			out_ready <= ($urandom_range(0, 3) != 0);
	end

	// result checker and watchdog
	always @(posedge clk) begin
		inverse_t e;
		bit bad;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles > 20000) begin
				$display("Verification failed");
				$finish;
			end
		end
		if (out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10) $display("unexpected output word");
			end else begin
				e = expected_q.pop_front();
				bad = (e.det !== det_value) || (e.sing !== singular);
				for (int i = 0; i < 9; i++) if (e.inv[i] !== inv[i]) bad = 1;
				if (bad) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10) begin
						$display("mismatch: exp det %0d sing %0d, got det %0d sing %0d",
							e.det, e.sing, det_value, singular);
						for (int i = 0; i < 9; i++)
							$display("  inv[%0d] exp %0d got %0d", i, e.inv[i], inv[i]);
					end
				end
			end
		end
	end

	task automatic send_matrix(elem_t a [9]);
		if (burst_left == 0) begin
			gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
			burst_left = $urandom_range(1, 20);
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				repeat (gap_left) @(posedge clk);
			end
		end
		burst_left--;
		for (int i = 0; i < 9; i++) m[i] <= a[i];
		in_valid <= 1'b1;
		expected_q.push_back(invert_matrix(a, size_reg));
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic set_size(logic [CFG_W-1:0] sz);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= sz;
		@(posedge clk);
		cfg_we <= 1'b0;
		size_reg = sz;
	endtask

	function automatic elem_t rand_elem();
		case ($urandom_range(0, 5))
			0: return elem_t'($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
			1: return elem_t'($signed($urandom_range(0, 1023)) - 512);
			2: return elem_t'($urandom_range(0, 1) ? 16'sh0100 : -16'sh0100);
			default: return elem_t'($urandom);
		endcase
	endfunction

	task automatic test_directed;
		elem_t a [9];
		for (int s = 0; s < 2; s++) begin
			set_size(s == 0 ? SIZE_RESET : SIZE_2X2);
			a = '{16'sh0100, 0, 0, 0, 16'sh0100, 0, 0, 0, 16'sh0100};
			send_matrix(a);
			a = '{default: 16'sh7fff};
			send_matrix(a);
			a = '{default: 16'sh8000};
			send_matrix(a);
			a = '{default: 0};
			send_matrix(a);
			a = '{16'sh0001, 0, 0, 0, 16'sh0001, 0, 0, 0, 16'sh0001};
			send_matrix(a);
			a = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
				16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh0001};
			send_matrix(a);
			a = '{16'sh7fff, 16'sh0001, 16'sh1234, 16'sh0002, 16'sh7fff,
				16'shffff, 16'sh8000, 16'sh5555, 16'shaaaa};
			send_matrix(a);
			a = '{16'sh0003, 16'sh0001, 16'sh8000, 16'sh0002, 16'sh0001,
				16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000};
			send_matrix(a);
		end
	endtask

	task automatic test_random(int count);
		elem_t a [9];
		for (int n = 0; n < count; n++) begin
			for (int i = 0; i < 9; i++) a[i] = rand_elem();
			// duplicate the top row (singular), or zero a[0] and a[1] (singular in 2x2 mode)
			if ($urandom_range(0, 9) == 0)
				for (int i = 0; i < 3; i++) a[3 + i] = a[i];
			if ($urandom_range(0, 19) == 0) begin
				a[0] = 0;
				a[1] = 0;
			end
			send_matrix(a);
		end
	endtask

	task automatic test_size_codes;
		set_size(2'd0);
		test_random(150);
		set_size(2'd1);
		test_random(150);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		set_size(SIZE_2X2);
		test_random(500);
		set_size(SIZE_RESET);
		test_random(500);
		test_size_codes();
		set_size(SIZE_2X2);
		test_random(100);
		drain();
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire
